[rtl/core/jsu_pkg.sv]
`timescale 1ns / 1ps
// Package for the JSON string unescaper: result types, decode modes and byte codes.
// No dependencies; used by jsu_decode, jsu_outbuf and json_string_unescaper.
package jsu_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_done;
        logic       closed_by_quote;
        logic       last;
    } t_result;

    // Up to four results caused by one item, in emission order from entry 0.
    typedef struct packed {
        t_result [3:0] res;
        logic [2:0]    count;
    } t_result_set;

    // Leading part of a result set: UTF-8 bytes or a literal backslash.
    typedef struct packed {
        t_result [3:0] res;
        logic [2:0]    len;
    } t_prefix;

    localparam int unsigned SET_DEPTH = 4;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_0      = 8'h30;
    localparam logic [7:0] CHR_9      = 8'h39;
    localparam logic [7:0] CHR_LA     = 8'h61;
    localparam logic [7:0] CHR_LF_HEX = 8'h66;
    localparam logic [7:0] CHR_UA     = 8'h41;
    localparam logic [7:0] CHR_UF     = 8'h46;

    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;

    function automatic t_result byte_result(input logic [7:0] b);
        t_result r;
        r.out_byte        = b;
        r.string_done     = 1'b0;
        r.closed_by_quote = 1'b0;
        r.last            = 1'b0;
        return r;
    endfunction

    function automatic t_result done_result(input logic by_quote);
        t_result r;
        r.out_byte        = 8'h00;
        r.string_done     = 1'b1;
        r.closed_by_quote = by_quote;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

[rtl/core/jsu_decode.sv]
`timescale 1ns / 1ps
// Decode state machine: mode, hex digit count and code point, plus the
// combinational expansion of one byte into its result set. Uses jsu_pkg.
module jsu_decode import jsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output t_result_set o_set
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_cp, n_cp;

    function automatic t_prefix utf8_bytes(input logic [15:0] v);
        t_prefix p;
        p = '0;
        if (v < UTF8_LIM1) begin
            p.res[0] = byte_result(v[7:0]);
            p.len    = 3'd1;
        end else if (v < UTF8_LIM2) begin
            p.res[0] = byte_result(UTF8_LEAD2 | {3'b000, v[10:6]});
            p.res[1] = byte_result(UTF8_CONT | {2'b00, v[5:0]});
            p.len    = 3'd2;
        end else begin
            p.res[0] = byte_result(UTF8_LEAD3 | {4'b0000, v[15:12]});
            p.res[1] = byte_result(UTF8_CONT | {2'b00, v[11:6]});
            p.res[2] = byte_result(UTF8_CONT | {2'b00, v[5:0]});
            p.len    = 3'd3;
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= 2'd0;
            r_cp   <= 16'h0000;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_cp   <= n_cp;
        end
    end

    always_comb begin
        t_prefix     pre;
        t_result     tail;
        logic        has_tail;
        t_result     nb_res;
        logic        nb_has;
        logic        nb_esc;
        logic        hex_ok;
        logic [7:0]  hex_diff;
        logic [15:0] cp_new;
        logic [2:0]  count;
        t_result     slot;

        // Plain-byte handling, shared by normal mode and a hex run cut short.
        nb_has = 1'b1;
        nb_esc = 1'b0;
        if (i_byte == CHR_NUL) begin
            nb_res = done_result(1'b0);
        end else if (i_byte == CHR_QUOTE) begin
            nb_res = done_result(1'b1);
        end else if (i_byte == CHR_BSLASH) begin
            nb_res = '0;
            nb_has = 1'b0;
            nb_esc = 1'b1;
        end else begin
            nb_res = byte_result(i_byte);
        end

        hex_ok   = 1'b1;
        if (i_byte >= CHR_0 && i_byte <= CHR_9) begin
            hex_diff = i_byte - CHR_0;
        end else if (i_byte >= CHR_LA && i_byte <= CHR_LF_HEX) begin
            hex_diff = i_byte - CHR_LA + 8'd10;
        end else if (i_byte >= CHR_UA && i_byte <= CHR_UF) begin
            hex_diff = i_byte - CHR_UA + 8'd10;
        end else begin
            hex_diff = 8'h00;
            hex_ok   = 1'b0;
        end
        cp_new = {r_cp[11:0], hex_diff[3:0]};

        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_cp     = r_cp;
        pre      = '0;
        tail     = '0;
        has_tail = 1'b0;

        case (r_mode)
            MODE_ESCAPE: begin
                n_mode   = MODE_NORMAL;
                has_tail = 1'b1;
                case (i_byte)
                    CHR_NUL: begin
                        pre.res[0] = byte_result(CHR_BSLASH);
                        pre.len    = 3'd1;
                        tail       = done_result(1'b0);
                        n_cnt      = 2'd0;
                        n_cp       = 16'h0000;
                    end
                    CHR_N: tail = byte_result(CTL_LF);
                    CHR_R: tail = byte_result(CTL_CR);
                    CHR_T: tail = byte_result(CTL_TAB);
                    CHR_B: tail = byte_result(CTL_BS);
                    CHR_F: tail = byte_result(CTL_FF);
                    CHR_U: begin
                        has_tail = 1'b0;
                        n_mode   = MODE_HEX;
                        n_cnt    = 2'd0;
                        n_cp     = 16'h0000;
                    end
                    default: tail = byte_result(i_byte);
                endcase
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    if (r_cnt == 2'd3) begin
                        pre    = utf8_bytes(cp_new);
                        n_mode = MODE_NORMAL;
                        n_cnt  = 2'd0;
                        n_cp   = 16'h0000;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                        n_cp  = cp_new;
                    end
                end else begin
                    pre      = utf8_bytes(r_cp);
                    n_mode   = nb_esc ? MODE_ESCAPE : MODE_NORMAL;
                    n_cnt    = 2'd0;
                    n_cp     = 16'h0000;
                    tail     = nb_res;
                    has_tail = nb_has;
                end
            end
            default: begin
                n_mode   = nb_esc ? MODE_ESCAPE : MODE_NORMAL;
                n_cnt    = 2'd0;
                n_cp     = 16'h0000;
                tail     = nb_res;
                has_tail = nb_has;
            end
        endcase

        count       = pre.len + {2'b00, has_tail};
        o_set.count = count;
        for (int i = 0; i < SET_DEPTH; i++) begin
            slot = '0;
            if (3'(i) < pre.len) begin
                slot = pre.res[i];
            end else if (has_tail && 3'(i) == pre.len) begin
                slot = tail;
            end
            slot.last    = (count != 3'd0) && (3'(i) == count - 3'd1);
            o_set.res[i] = slot;
        end
    end

endmodule

[rtl/core/jsu_outbuf.sv]
`timescale 1ns / 1ps
// Result register: holds the result set of one item and shifts it out one
// result per handshake. Uses jsu_pkg.
module jsu_outbuf import jsu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result_set i_set,
    input  logic        i_take,
    output logic        o_valid,
    output logic        o_room,
    output t_result     o_head
);

    t_result [3:0] r_q, n_q;
    logic [2:0]    r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (i_load) begin
            n_q   = i_set.res;
            n_cnt = i_set.count;
        end else if (i_take) begin
            for (int i = 0; i < SET_DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            n_q[SET_DEPTH - 1] = '0;
            n_cnt              = r_cnt - 3'd1;
        end
    end

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_take);
    assign o_head  = r_q[0];

endmodule

[rtl/core/json_string_unescaper.sv]
`timescale 1ns / 1ps
// Top level of the JSON string unescaper. Depends on jsu_pkg, jsu_decode and jsu_outbuf.
//
// Feed the bytes of a JSON string body, one byte per item, starting after the
// opening quote. Each item passes through an input register, is expanded by the
// decoder into zero to four results, and those results leave one per cycle from
// the result register while i_stall is low, so plain text streams at one byte
// per clock when the output is not stalled; an item that yields several results
// (two or three for UTF-8 from a \u escape, two for backslash-NUL, one more when
// a non-hex byte cuts a \u run short) holds the input until they have left, as
// the result register has a single output port. An item's first result appears
// once it has passed the input register and the result register. Done results
// (closing quote or NUL) reset the decoder, so the next item starts a new string.
module json_string_unescaper import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_string_done,
    output logic       o_closed_by_quote,
    output logic       o_last
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        move;
    logic        room;
    logic        take;
    t_result_set dec_set;
    t_result     head;

    // Advance the held item into the result register as soon as the last
    // pending result leaves, so single-result items stream without bubbles.
    assign take    = o_valid && !i_stall;
    assign move    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload needs no reset; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Decoder state advances only when its item moves on.
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (move),
        .i_byte  (r_in_byte),
        .o_set   (dec_set)
    );

    jsu_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (move),
        .i_set   (dec_set),
        .i_take  (take),
        .o_valid (o_valid),
        .o_room  (room),
        .o_head  (head)
    );

    assign o_out_byte        = head.out_byte;
    assign o_string_done     = head.string_done;
    assign o_closed_by_quote = head.closed_by_quote;
    assign o_last            = head.last;

endmodule

[rtl/core/jsu_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for json_string_unescaper, attached by the bind below.
// Depends only on the top-level port list.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_string_done,
    input logic       o_closed_by_quote,
    input logic       o_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte)
            && $stable(o_string_done) && $stable(o_closed_by_quote) && $stable(o_last))
        else $error("stalled result changed");

    // A done result ends its item's results and carries no byte.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_done |-> o_last && o_out_byte == 8'h00)
        else $error("done result not last or carries a byte");

    a_byte_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_string_done |-> !o_closed_by_quote)
        else $error("quote flag set on a byte result");

    // Reset empties both the input and result registers.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_out_byte        (o_out_byte),
    .o_string_done     (o_string_done),
    .o_closed_by_quote (o_closed_by_quote),
    .o_last            (o_last)
);
